>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/trc_pkg.sv
// Types, constants and helper functions for the two-rotor cipher.
`default_nettype none

package trc_pkg;

    localparam int unsigned LETTERS = 26;
    localparam int unsigned OFS_W   = 5;
    localparam int unsigned CFG_W   = 60;

    localparam logic [7:0] CODE_A     = 8'd65;
    localparam logic [7:0] CODE_Z     = 8'd90;
    localparam logic [7:0] CODE_SPACE = 8'd32;

    typedef logic [OFS_W-1:0] ofs_t;
    typedef logic [LETTERS-1:0][OFS_W-1:0] rotor_t;
    typedef logic [LETTERS-1:0] match_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DIRECTION  = 3'd0,
        CFG_ROTOR1_LOW = 3'd1,
        CFG_ROTOR1_MID = 3'd2,
        CFG_ROTOR1_HI  = 3'd3,
        CFG_ROTOR2_LOW = 3'd4,
        CFG_ROTOR2_MID = 3'd5,
        CFG_ROTOR2_HI  = 3'd6
    } cfg_index_t;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    // (a + b) mod 26 for a, b below 26
    function automatic ofs_t add_mod26(input ofs_t a, input ofs_t b);
        logic [OFS_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (OFS_W+1)'(LETTERS))
        begin
            sum = sum - (OFS_W+1)'(LETTERS);
        end
        return sum[OFS_W-1:0];
    endfunction

    // bit p of result = bit (p + off) mod 26 of v
    function automatic match_t rotate26(input match_t v, input ofs_t off);
        match_t r;
        for (int p = 0; p < LETTERS; p++)
        begin
            r[p] = v[add_mod26(OFS_W'(p), off)];
        end
        return r;
    endfunction

    // lowest set position, 26 when none
    function automatic ofs_t first_set(input match_t v);
        ofs_t pos;
        pos = OFS_W'(LETTERS);
        for (int i = LETTERS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = OFS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/two_rotor_cipher.sv
// Two-rotor substitution cipher, one character byte per item.
//
// Letters 'A'..'Z' go through two 26-entry rotors (encode: rotor one then
// rotor two; decode: inverse searches in reverse order); a space passes
// unchanged; any other byte passes unchanged with not_letter set. The fast
// offset steps after each letter, the slow offset when the fast one wraps,
// and message_start clears both before its own item. The block takes one
// item every clock cycle unless the result side stalls. An accepted item is
// held in the input register and passes, through the rotor lookup or the two
// match-and-priority searches, to the result register once that is empty or
// taken. Offsets are resolved at acceptance, so back-to-back letters step
// correctly. in_ready follows out_ready combinationally through the two-stage
// pipe. The user must write configuration (direction and the packed rotor
// words) through cfg_we / cfg_index / cfg_data only while no item is in flight;
// the block does not enforce it. Indexes past the last register are ignored.
`default_nettype none

module two_rotor_cipher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [59:0] cfg_data,
    // input item channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_in,
    input  wire logic        message_start,
    // result item channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       char_out,
    output logic             not_letter
);

    // configuration
    trc_pkg::dir_t   direction_reg;
    trc_pkg::rotor_t rotor1_reg;
    trc_pkg::rotor_t rotor2_reg;

    // rotor offsets
    trc_pkg::ofs_t fast_reg, fast_next;
    trc_pkg::ofs_t slow_reg, slow_next;
    trc_pkg::ofs_t fast_eff, slow_eff;

    // stage 1: captured item with the offsets it uses
    logic          s1_valid_reg;
    logic [7:0]    s1_char_reg;
    trc_pkg::ofs_t s1_fast_reg;
    trc_pkg::ofs_t s1_slow_reg;

    // stage 2: result register
    logic       out_valid_reg;
    logic [7:0] char_out_reg;
    logic       not_letter_reg;

    logic in_fire;
    logic s1_advance;
    logic in_is_letter;

    // stage 1 datapath
    logic          s1_is_letter;
    logic          s1_is_space;
    trc_pkg::ofs_t letter_idx;
    trc_pkg::ofs_t enc_mid;
    trc_pkg::ofs_t enc_mid26;
    trc_pkg::ofs_t enc_out;
    trc_pkg::ofs_t dec_mid;
    trc_pkg::ofs_t dec_out;
    trc_pkg::match_t match2;
    trc_pkg::match_t match1;
    logic [7:0]    letter_result;
    logic [7:0]    char_out_next;
    logic          not_letter_next;

    // handshake: result register frees when empty or taken
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= trc_pkg::DIR_ENCODE;
            rotor1_reg    <= '0;
            rotor2_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                trc_pkg::CFG_DIRECTION:  direction_reg <= trc_pkg::dir_t'(cfg_data[0]);
                trc_pkg::CFG_ROTOR1_LOW: rotor1_reg[11:0]  <= cfg_data;
                trc_pkg::CFG_ROTOR1_MID: rotor1_reg[23:12] <= cfg_data;
                trc_pkg::CFG_ROTOR1_HI:  rotor1_reg[25:24] <= cfg_data[9:0];
                trc_pkg::CFG_ROTOR2_LOW: rotor2_reg[11:0]  <= cfg_data;
                trc_pkg::CFG_ROTOR2_MID: rotor2_reg[23:12] <= cfg_data;
                trc_pkg::CFG_ROTOR2_HI:  rotor2_reg[25:24] <= cfg_data[9:0];
                default: ;  // unused index: ignored
            endcase
        end
    end

    // offset stepping, resolved when the item is accepted
    assign in_is_letter = (char_in >= trc_pkg::CODE_A) && (char_in <= trc_pkg::CODE_Z);
    assign fast_eff     = message_start ? '0 : fast_reg;
    assign slow_eff     = message_start ? '0 : slow_reg;

    always_comb
    begin
        fast_next = fast_eff;
        slow_next = slow_eff;
        if (in_is_letter)
        begin
            if (fast_eff == trc_pkg::ofs_t'(trc_pkg::LETTERS - 1))
            begin
                fast_next = '0;
                slow_next = (slow_eff == trc_pkg::ofs_t'(trc_pkg::LETTERS - 1)) ?
                            '0 : slow_eff + 1'b1;
            end
            else
            begin
                fast_next = fast_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg     <= '0;
            slow_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                fast_reg <= fast_next;
                slow_reg <= slow_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= char_in;
            s1_fast_reg <= fast_eff;
            s1_slow_reg <= slow_eff;
        end
    end

    // cipher datapath between the input and result registers
    always_comb
    begin
        s1_is_letter = (s1_char_reg >= trc_pkg::CODE_A) && (s1_char_reg <= trc_pkg::CODE_Z);
        s1_is_space  = (s1_char_reg == trc_pkg::CODE_SPACE);
        letter_idx   = trc_pkg::ofs_t'(s1_char_reg - trc_pkg::CODE_A);

        // encode: direct lookups; an out-of-range rotor one entry wraps mod 26
        enc_mid   = rotor1_reg[trc_pkg::add_mod26(letter_idx, s1_fast_reg)];
        enc_mid26 = (enc_mid >= trc_pkg::ofs_t'(trc_pkg::LETTERS)) ?
                    enc_mid - trc_pkg::ofs_t'(trc_pkg::LETTERS) : enc_mid;
        enc_out   = rotor2_reg[trc_pkg::add_mod26(enc_mid26, s1_slow_reg)];

        // decode: match all entries, rotate the match vector, take the lowest
        for (int k = 0; k < trc_pkg::LETTERS; k++)
        begin
            match2[k] = (rotor2_reg[k] == letter_idx);
        end
        dec_mid = trc_pkg::first_set(trc_pkg::rotate26(match2, s1_slow_reg));
        for (int k = 0; k < trc_pkg::LETTERS; k++)
        begin
            match1[k] = (rotor1_reg[k] == dec_mid);
        end
        dec_out = trc_pkg::first_set(trc_pkg::rotate26(match1, s1_fast_reg));

        letter_result = (direction_reg == trc_pkg::DIR_DECODE) ?
                        {3'b000, dec_out} + trc_pkg::CODE_A :
                        {3'b000, enc_out} + trc_pkg::CODE_A;

        char_out_next   = s1_is_letter ? letter_result : s1_char_reg;
        not_letter_next = !s1_is_letter && !s1_is_space;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            char_out_reg   <= char_out_next;
            not_letter_reg <= not_letter_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_out   = char_out_reg;
    assign not_letter = not_letter_reg;

endmodule

`default_nettype wire

>>> rtl/core/trc_checker.sv
// Port-level checker for the two-rotor cipher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module trc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] char_out,
    input wire logic       not_letter
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(char_out) && $stable(not_letter))

    // an empty result register never blocks the input
    `ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // flagged items are passed through bytes, never a letter or a space
    `ASSERT_NOW(a_flag_passthru, clk, rst_n, out_valid && not_letter, (char_out < 8'd65 || char_out > 8'd90) && char_out != 8'd32)

    // unflagged results are a space or a rotor output plus 'A'
    `ASSERT_NOW(a_letter_range, clk, rst_n, out_valid && !not_letter, char_out == 8'd32 || (char_out >= 8'd65 && char_out <= 8'd96))

endmodule

bind two_rotor_cipher trc_checker u_trc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_out   (char_out),
    .not_letter (not_letter)
);

`default_nettype wire

>>> verif/two_rotor_cipher_checker.sv
// Checker for the two-rotor cipher: mirrors config, predicts each result and compares.
`default_nettype none

module two_rotor_cipher_checker
    import trc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [59:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  char_in,
    input  wire logic        message_start,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  char_out,
    input  wire logic        not_letter,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [7:0] ch;
        logic       odd_byte;
    } cipher_out_t;

    cipher_out_t pending_chars[$];

    dir_t   direction;
    rotor_t rotor_one;
    rotor_t rotor_two;
    ofs_t   fast_ofs;
    ofs_t   slow_ofs;

    // lowest rotated position holding value, LETTERS when absent
    function automatic int rotor_pos(input rotor_t r, input int value, input int ofs);
        for (int p = 0; p < LETTERS; p++)
        begin
            if (int'(r[(p + ofs) % LETTERS]) == value)
            begin
                return p;
            end
        end
        return LETTERS;
    endfunction

    // append one predicted item at the tail
    task automatic queue_result(input cipher_out_t item);
        pending_chars = {pending_chars, item};
    endtask

    task automatic cipher_step(input logic [7:0] c, input logic start);
        int mid;
        int res;
        int t;
        if (start)
        begin
            fast_ofs = '0;
            slow_ofs = '0;
        end
        if (c >= CODE_A && c <= CODE_Z)
        begin
            t = int'(c - CODE_A);
            if (direction == DIR_ENCODE)
            begin
                mid = int'(rotor_one[(t + int'(fast_ofs)) % LETTERS]);
                res = int'(rotor_two[(mid % LETTERS + int'(slow_ofs)) % LETTERS]) + int'(CODE_A);
            end
            else
            begin
                mid = rotor_pos(rotor_two, t, int'(slow_ofs));
                res = rotor_pos(rotor_one, mid, int'(fast_ofs)) + int'(CODE_A);
            end
            if (fast_ofs == ofs_t'(LETTERS - 1))
            begin
                fast_ofs = '0;
                slow_ofs = (slow_ofs == ofs_t'(LETTERS - 1)) ? '0 : slow_ofs + 1'b1;
            end
            else
            begin
                fast_ofs = fast_ofs + 1'b1;
            end
            queue_result('{ch: res[7:0], odd_byte: 1'b0});
        end
        else
        begin
            queue_result('{ch: c, odd_byte: (c != CODE_SPACE)});
        end
    endtask

    always @(posedge clk)
    begin
        cipher_out_t want;
        if (!rst_n)
        begin
            direction   = DIR_ENCODE;
            rotor_one   = '0;
            rotor_two   = '0;
            fast_ofs    = '0;
            slow_ofs    = '0;
            mismatches  = 0;
            pending_chars.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIRECTION:  direction = dir_t'(cfg_data[0]);
                    CFG_ROTOR1_LOW: rotor_one[11:0]  = cfg_data;
                    CFG_ROTOR1_MID: rotor_one[23:12] = cfg_data;
                    CFG_ROTOR1_HI:  rotor_one[25:24] = cfg_data[9:0];
                    CFG_ROTOR2_LOW: rotor_two[11:0]  = cfg_data;
                    CFG_ROTOR2_MID: rotor_two[23:12] = cfg_data;
                    CFG_ROTOR2_HI:  rotor_two[25:24] = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                cipher_step(char_in, message_start);
            end
            if (out_valid && out_ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got char_out %02h not_letter %b",
                             $time, char_out, not_letter);
                    mismatches++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (char_out !== want.ch)
                    begin
                        $display("%0t: char_out expected %02h, got %02h",
                                 $time, want.ch, char_out);
                        mismatches++;
                    end
                    if (not_letter !== want.odd_byte)
                    begin
                        $display("%0t: not_letter expected %b, got %b",
                                 $time, want.odd_byte, not_letter);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = pending_chars.size();
    end

endmodule

`default_nettype wire

>>> verif/tb_two_rotor_cipher.sv
// Testbench top for the two-rotor cipher: stimulus, handshake pacing and verdict.
`default_nettype none

module tb_two_rotor_cipher;
    import trc_pkg::*;

    // index past the last register; the block must ignore writes to it
    localparam logic [2:0] CFG_NONE = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [59:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_in;
    logic        message_start;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  char_out;
    logic        not_letter;

    int     mismatches;
    int     outstanding;
    // when set, neither side idles: back-to-back items in both directions
    bit     calm;
    rotor_t perm_one;
    rotor_t perm_two;

    always #2 clk = ~clk;

    two_rotor_cipher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_in       (char_in),
        .message_start (message_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_out      (char_out),
        .not_letter    (not_letter)
    );

    two_rotor_cipher_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_in       (char_in),
        .message_start (message_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_out      (char_out),
        .not_letter    (not_letter),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Hard stop in case the block hangs or drops items.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: before each item, hold ready low for a randomly drawn stall,
    // then keep it high until the item is taken. Changes only on falling edges.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 13);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    function automatic rotor_t shuffled_rotor();
        rotor_t     r;
        int         j;
        logic [4:0] tmp;
        for (int k = 0; k < LETTERS; k++)
        begin
            r[k] = 5'(k);
        end
        for (int k = LETTERS - 1; k > 0; k--)
        begin
            j    = $urandom_range(0, k);
            tmp  = r[k];
            r[k] = r[j];
            r[j] = tmp;
        end
        return r;
    endfunction

    function automatic logic [59:0] rand60();
        return 60'({$urandom(), $urandom()});
    endfunction

    // One register write; the enable is dropped again on the next falling edge.
    task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Packed rotor entry k sits at bits 5k+4..5k, same as the register packing.
    task automatic load_rotors(input rotor_t one, input rotor_t two);
        logic [129:0] a;
        logic [129:0] b;
        a = one;
        b = two;
        write_reg(CFG_ROTOR1_LOW, a[59:0]);
        write_reg(CFG_ROTOR1_MID, a[119:60]);
        write_reg(CFG_ROTOR1_HI,  60'(a[129:120]));
        write_reg(CFG_ROTOR2_LOW, b[59:0]);
        write_reg(CFG_ROTOR2_MID, b[119:60]);
        write_reg(CFG_ROTOR2_HI,  60'(b[129:120]));
    endtask

    // Offer one item after a random gap and hold it until accepted. When the
    // gap is zero, valid stays high and only the payload moves on.
    task automatic send_char(input logic [7:0] c, input logic start);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        char_in       <= c;
        message_start <= start;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Sender stops and waits for every predicted item, plus pipeline slack,
    // so config writes land on an idle block.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Mostly well-formed messages: start flag on the first item, then mostly
    // letters with a few spaces and stray bytes. One message in five is noise:
    // any byte, start flag at random.
    task automatic random_traffic(input int count);
        int         sent;
        int         len;
        int         pick;
        bit         noisy;
        logic [7:0] c;
        logic       s;
        sent = 0;
        while (sent < count)
        begin
            len   = $urandom_range(1, 40);
            noisy = ($urandom_range(0, 4) == 0);
            calm  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len && sent < count; i++)
            begin
                pick = $urandom_range(0, 99);
                if (noisy)
                begin
                    c = 8'($urandom_range(0, 255));
                    s = ($urandom_range(0, 3) == 0);
                end
                else
                begin
                    s = (i == 0);
                    if (pick < 85)
                        c = CODE_A + 8'($urandom_range(0, LETTERS - 1));
                    else if (pick < 93)
                        c = CODE_SPACE;
                    else
                        c = 8'($urandom_range(0, 255));
                end
                send_char(c, s);
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int letters;
        int pick;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_DIRECTION;
        cfg_data      = '0;
        in_valid      = 1'b0;
        char_in       = '0;
        message_start = 1'b0;
        calm          = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset config: encode, both rotors all zero, so every letter gives 'A'.
        // Edges of the letter range, space and stray bytes, start flag on a
        // space and on a non-letter.
        send_char(CODE_A, 1'b1);
        send_char(CODE_Z, 1'b0);
        send_char(CODE_A - 8'd1, 1'b0);
        send_char(CODE_Z + 8'd1, 1'b0);
        send_char(CODE_SPACE, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h61, 1'b0);
        random_traffic(40);
        settle();

        // Real permutations, encode.
        perm_one = shuffled_rotor();
        perm_two = shuffled_rotor();
        load_rotors(perm_one, perm_two);
        send_char(CODE_A, 1'b1);
        send_char(CODE_Z, 1'b0);
        random_traffic(60);
        settle();

        // Same rotors, decode; a write to the unused index must change nothing.
        write_reg(CFG_DIRECTION, 60'(DIR_DECODE));
        write_reg(CFG_NONE, '1);
        send_char(CODE_A, 1'b1);
        send_char(CODE_Z, 1'b0);
        random_traffic(60);
        settle();

        // All ones everywhere: direction decode, every entry 31. No search
        // matches, so decoded letters come out as the no-match code.
        write_reg(CFG_DIRECTION,  '1);
        write_reg(CFG_ROTOR1_LOW, '1);
        write_reg(CFG_ROTOR1_MID, '1);
        write_reg(CFG_ROTOR1_HI,  '1);
        write_reg(CFG_ROTOR2_LOW, '1);
        write_reg(CFG_ROTOR2_MID, '1);
        write_reg(CFG_ROTOR2_HI,  '1);
        send_char(CODE_A, 1'b1);
        send_char(CODE_Z, 1'b0);
        random_traffic(30);
        settle();

        // Encode with out-of-range entries: rotor one feeds 31 mod 26 into
        // rotor two, whose output is not a letter.
        write_reg(CFG_DIRECTION, 60'(DIR_ENCODE));
        send_char(CODE_A + 8'd1, 1'b1);
        random_traffic(30);
        settle();

        // Arbitrary words: repeated entries (lowest position wins on decode)
        // and entries above 25.
        write_reg(CFG_ROTOR1_LOW, rand60());
        write_reg(CFG_ROTOR1_MID, rand60());
        write_reg(CFG_ROTOR1_HI,  rand60());
        write_reg(CFG_ROTOR2_LOW, rand60());
        write_reg(CFG_ROTOR2_MID, rand60());
        write_reg(CFG_ROTOR2_HI,  rand60());
        write_reg(CFG_DIRECTION, 60'(DIR_DECODE));
        random_traffic(50);
        settle();
        write_reg(CFG_DIRECTION, 60'(DIR_ENCODE));
        random_traffic(50);
        settle();

        // One long message, no restart: 250 letters take the fast offset
        // through several full turns and step the slow offset each time.
        // Pacing flips now and then.
        load_rotors(perm_one, perm_two);
        write_reg(CFG_DIRECTION, 60'(DIR_DECODE));
        calm = $urandom_range(0, 1);
        send_char(CODE_A, 1'b1);
        letters = 1;
        while (letters < 250)
        begin
            if ($urandom_range(0, 49) == 0)
                calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick == 0)
                send_char(CODE_SPACE, 1'b0);
            else if (pick < 3)
                send_char(8'($urandom_range(0, 255)), 1'b0);
            else
            begin
                send_char(CODE_A + 8'($urandom_range(0, LETTERS - 1)), 1'b0);
                letters++;
            end
        end
        calm = 1'b0;
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/trc_pkg.sv
rtl/core/two_rotor_cipher.sv
rtl/core/trc_checker.sv
verif/two_rotor_cipher_checker.sv
verif/tb_two_rotor_cipher.sv
